// ===== rtl/lcdt_pkg.sv =====
// Shared types, codes and timing constants of the LCD register and mode timing unit.
package lcdt_pkg;

    // Request commands
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_WRITE = 2'd2;

    // Output mode codes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_VRAM   = 2'd3;

    // Dot budgets per mode
    localparam int          DOT_W       = 10;
    localparam logic [9:0]  OAM_DOTS    = 10'd80;
    localparam logic [9:0]  VRAM_DOTS   = 10'd172;
    localparam logic [9:0]  HBLANK_DOTS = 10'd204;
    localparam logic [9:0]  LINE_DOTS   = 10'd456;
    localparam logic [9:0]  DOT_MAX     = 10'h3FF;
    localparam logic [7:0]  LAST_LINE   = 8'd153;
    localparam int          STAT_VBLANK_BIT = 4;

    // Register addresses
    localparam logic [15:0] ADDR_LCDC = 16'hFF40;
    localparam logic [15:0] ADDR_STAT = 16'hFF41;
    localparam logic [15:0] ADDR_SCY  = 16'hFF42;
    localparam logic [15:0] ADDR_SCX  = 16'hFF43;
    localparam logic [15:0] ADDR_LY   = 16'hFF44;
    localparam logic [15:0] ADDR_LYC  = 16'hFF45;
    localparam logic [15:0] ADDR_BGP  = 16'hFF47;
    localparam logic [15:0] ADDR_OBP0 = 16'hFF48;
    localparam logic [15:0] ADDR_OBP1 = 16'hFF49;
    localparam logic [15:0] ADDR_WY   = 16'hFF4A;
    localparam logic [15:0] ADDR_WX   = 16'hFF4B;

    localparam logic [7:0]  PALETTE_RESET = 8'hE4;

    // Scanline mode state, one-hot
    typedef enum logic [3:0] {
        ST_HBLANK = 4'b0001,
        ST_VBLANK = 4'b0010,
        ST_OAM    = 4'b0100,
        ST_VRAM   = 4'b1000
    } t_lcd_state;

    // Event pulses of one tick
    typedef struct packed {
        logic vblank_irq;
        logic stat_irq;
        logic render_line;
        logic frame_ready;
    } t_lcd_pulses;

    function automatic logic [1:0] state_to_mode(input t_lcd_state st);
        logic [1:0] m;
        unique case (st)
            ST_HBLANK: m = MODE_HBLANK;
            ST_VBLANK: m = MODE_VBLANK;
            ST_OAM:    m = MODE_OAM;
            ST_VRAM:   m = MODE_VRAM;
            default:   m = MODE_OAM;
        endcase
        return m;
    endfunction

endpackage

// ===== rtl/lcd_registers_and_mode_timing_unit.sv =====
// Top level of the LCD register file and scanline mode timing unit.
//
//  channel  direction  handshake            payload
//  request  in         i_valid / o_stall    i_cmd, i_addr, i_wdata, i_cycles
//  result   out        o_valid / i_stall    o_rdata, o_mode, o_line, o_vblank_irq,
//                                           o_stat_irq, o_render_line, o_frame_ready
//
// Each request passes through the input register, then through the register bank / mode
// sequencer into the result register. A new request is taken every cycle while o_stall
// is low.
// Reset (i_rst_n low, synchronous) empties both stages and restores register defaults.
// A stalled result holds the result register, which backs up into the input register
// and then raises o_stall.
module lcd_registers_and_mode_timing_unit #(
    parameter int VISIBLE_LINES = 144
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [7:0]  i_cycles,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_rdata,
    output logic [1:0]  o_mode,
    output logic [7:0]  o_line,
    output logic        o_vblank_irq,
    output logic        o_stat_irq,
    output logic        o_render_line,
    output logic        o_frame_ready
);
    import lcdt_pkg::*;

    // Input register
    logic        r_in_valid;
    logic [1:0]  r_cmd;
    logic [15:0] r_addr;
    logic [7:0]  r_wdata;
    logic [7:0]  r_cycles;

    // Result register
    logic        r_out_valid;
    logic [7:0]  r_rdata;
    logic [1:0]  r_mode;
    logic [7:0]  r_line;
    t_lcd_pulses r_pulses;

    logic        w_advance;
    logic        w_fire;
    logic [7:0]  w_rdata;
    logic        w_stat_vblank_en;
    logic [7:0]  w_cur_line;
    logic [1:0]  w_next_mode;
    logic [7:0]  w_next_line;
    t_lcd_pulses w_pulses;

    // The result register can load when empty or when its result is taken.
    assign w_advance = !r_out_valid || !i_stall;
    assign w_fire    = r_in_valid && w_advance;
    assign o_stall   = r_in_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    // Hold the request payload while stalled.
    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_cmd    <= i_cmd;
            r_addr   <= i_addr;
            r_wdata  <= i_wdata;
            r_cycles <= i_cycles;
        end
    end

    lcdt_regfile u_regfile (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr_en          (w_fire && (r_cmd == CMD_WRITE)),
        .i_addr           (r_addr),
        .i_wdata          (r_wdata),
        .i_line           (w_cur_line),
        .o_rdata          (w_rdata),
        .o_stat_vblank_en (w_stat_vblank_en)
    );

    lcdt_mode_timer #(
        .VISIBLE_LINES (VISIBLE_LINES)
    ) u_mode_timer (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_tick           (w_fire && (r_cmd == CMD_TICK)),
        .i_cycles         (r_cycles),
        .i_stat_vblank_en (w_stat_vblank_en),
        .o_line           (w_cur_line),
        .o_next_mode      (w_next_mode),
        .o_next_line      (w_next_line),
        .o_pulses         (w_pulses)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    // Capture the result; read data only on reads, pulses only on ticks.
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_rdata  <= (r_cmd == CMD_READ) ? w_rdata : 8'h00;
            r_mode   <= w_next_mode;
            r_line   <= w_next_line;
            r_pulses <= w_pulses;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_rdata       = r_rdata;
    assign o_mode        = r_mode;
    assign o_line        = r_line;
    assign o_vblank_irq  = r_pulses.vblank_irq;
    assign o_stat_irq    = r_pulses.stat_irq;
    assign o_render_line = r_pulses.render_line;
    assign o_frame_ready = r_pulses.frame_ready;

endmodule

// ===== rtl/lcdt_regfile.sv =====
// Bus-visible register bank of the LCD controller.
module lcdt_regfile (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_wr_en,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_wdata,
    input  logic [7:0]  i_line,
    output logic [7:0]  o_rdata,
    output logic        o_stat_vblank_en
);
    import lcdt_pkg::*;

    logic [7:0] r_lcdc, r_stat, r_scy, r_scx, r_lyc, r_bgp, r_obp0, r_obp1, r_wy, r_wx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lcdc <= '0;
            r_stat <= '0;
            r_scy  <= '0;
            r_scx  <= '0;
            r_lyc  <= '0;
            r_wy   <= '0;
            r_wx   <= '0;
            r_bgp  <= PALETTE_RESET;
            r_obp0 <= PALETTE_RESET;
            r_obp1 <= PALETTE_RESET;
        end else if (i_wr_en) begin
            // drop writes to the line register and unmapped addresses
            unique case (i_addr)
                ADDR_LCDC: r_lcdc <= i_wdata;
                ADDR_STAT: r_stat <= i_wdata;
                ADDR_SCY:  r_scy  <= i_wdata;
                ADDR_SCX:  r_scx  <= i_wdata;
                ADDR_LYC:  r_lyc  <= i_wdata;
                ADDR_BGP:  r_bgp  <= i_wdata;
                ADDR_OBP0: r_obp0 <= i_wdata;
                ADDR_OBP1: r_obp1 <= i_wdata;
                ADDR_WY:   r_wy   <= i_wdata;
                ADDR_WX:   r_wx   <= i_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (i_addr)
            ADDR_LCDC: o_rdata = r_lcdc;
            ADDR_STAT: o_rdata = r_stat;
            ADDR_SCY:  o_rdata = r_scy;
            ADDR_SCX:  o_rdata = r_scx;
            ADDR_LY:   o_rdata = i_line;
            ADDR_LYC:  o_rdata = r_lyc;
            ADDR_BGP:  o_rdata = r_bgp;
            ADDR_OBP0: o_rdata = r_obp0;
            ADDR_OBP1: o_rdata = r_obp1;
            ADDR_WY:   o_rdata = r_wy;
            ADDR_WX:   o_rdata = r_wx;
            default:   o_rdata = 8'h00;
        endcase
    end

    assign o_stat_vblank_en = r_stat[STAT_VBLANK_BIT];

endmodule

// ===== rtl/lcdt_mode_timer.sv =====
// Dot counter, scanline counter and mode sequencer of the LCD controller.
module lcdt_mode_timer #(
    parameter int VISIBLE_LINES = 144
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_tick,
    input  logic [7:0]            i_cycles,
    input  logic                  i_stat_vblank_en,
    output logic [7:0]            o_line,
    output logic [1:0]            o_next_mode,
    output logic [7:0]            o_next_line,
    output lcdt_pkg::t_lcd_pulses o_pulses
);
    import lcdt_pkg::*;

    localparam logic [7:0] VisLines = 8'(VISIBLE_LINES);

    t_lcd_state       r_state, n_state;
    logic [DOT_W-1:0] r_dot, n_dot;
    logic [7:0]       r_line, n_line;
    logic [DOT_W:0]   w_sum;
    logic [DOT_W-1:0] w_sat;
    logic [7:0]       w_line_inc;

    assign w_sum      = {1'b0, r_dot} + {3'b000, i_cycles};
    assign w_sat      = w_sum[DOT_W] ? DOT_MAX : w_sum[DOT_W-1:0];
    assign w_line_inc = r_line + 8'd1;

    always_comb begin
        n_state  = r_state;
        n_dot    = r_dot;
        n_line   = r_line;
        o_pulses = '0;
        if (i_tick) begin
            n_dot = w_sat;
            unique case (r_state)
                ST_HBLANK: begin
                    if (w_sat >= HBLANK_DOTS) begin
                        n_dot  = w_sat - HBLANK_DOTS;
                        n_line = w_line_inc;
                        if (w_line_inc >= VisLines) begin
                            n_state              = ST_VBLANK;
                            o_pulses.vblank_irq  = 1'b1;
                            o_pulses.frame_ready = 1'b1;
                            o_pulses.stat_irq    = i_stat_vblank_en;
                        end else begin
                            n_state = ST_OAM;
                        end
                    end
                end
                ST_VBLANK: begin
                    if (w_sat >= LINE_DOTS) begin
                        n_dot  = w_sat - LINE_DOTS;
                        n_line = w_line_inc;
                        if (w_line_inc > LAST_LINE) begin
                            n_state = ST_OAM;
                            n_line  = 8'd0;
                        end
                    end
                end
                ST_OAM: begin
                    if (w_sat >= OAM_DOTS) begin
                        n_dot   = w_sat - OAM_DOTS;
                        n_state = ST_VRAM;
                    end
                end
                ST_VRAM: begin
                    if (w_sat >= VRAM_DOTS) begin
                        n_dot                = w_sat - VRAM_DOTS;
                        n_state              = ST_HBLANK;
                        o_pulses.render_line = 1'b1;
                    end
                end
                default: n_state = ST_OAM;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_OAM;
            r_dot   <= '0;
            r_line  <= '0;
        end else begin
            r_state <= n_state;
            r_dot   <= n_dot;
            r_line  <= n_line;
        end
    end

    assign o_line      = r_line;
    assign o_next_mode = state_to_mode(n_state);
    assign o_next_line = n_line;

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench for the LCD register file and scanline mode timing unit.
`timescale 1ns / 1ps

module tb;
    import lcdt_pkg::*;

    localparam int VISIBLE_LINES = 144;
    // Gap in the register window; reads give zero and writes do nothing
    localparam logic [15:0] ADDR_DMA = 16'hFF46;
    // The fourth command code has no function
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Longest run of cycles without any handshake before the run is declared hung
    localparam int HANG_LIMIT = 1000;
    // Length of the forced result hold-off that backs the pipe up
    localparam int LONG_HOLD = 80;
    // Cycles to keep watching after the last result, to catch stray outputs
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic [7:0]  rdata;
        logic [1:0]  mode;
        logic [7:0]  line;
        t_lcd_pulses pulses;
    } t_lcd_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [1:0]  i_cmd;
    logic [15:0] i_addr;
    logic [7:0]  i_wdata;
    logic [7:0]  i_cycles;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_rdata;
    logic [1:0]  o_mode;
    logic [7:0]  o_line;
    logic        o_vblank_irq;
    logic        o_stat_irq;
    logic        o_render_line;
    logic        o_frame_ready;

    // Predicted state of the block: dot counter, scanline mode, line and register bank
    int unsigned lcd_dots;
    logic [1:0]  lcd_mode;
    logic [7:0]  lcd_line;
    logic [7:0]  lcd_regs [16];

    t_lcd_result pending_results[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_request = 1'b0;

    lcd_registers_and_mode_timing_unit #(
        .VISIBLE_LINES(VISIBLE_LINES)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_addr        (i_addr),
        .i_wdata       (i_wdata),
        .i_cycles      (i_cycles),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_rdata       (o_rdata),
        .o_mode        (o_mode),
        .o_line        (o_line),
        .o_vblank_irq  (o_vblank_irq),
        .o_stat_irq    (o_stat_irq),
        .o_render_line (o_render_line),
        .o_frame_ready (o_frame_ready)
    );

    always #6 i_clk = ~i_clk;

    // Restore the predicted state to its power-on values
    task automatic reset_lcd_state();
        lcd_dots = 0;
        lcd_mode = MODE_OAM;
        lcd_line = 8'd0;
        foreach (lcd_regs[k]) lcd_regs[k] = 8'd0;
        lcd_regs[ADDR_BGP[3:0]]  = PALETTE_RESET;
        lcd_regs[ADDR_OBP0[3:0]] = PALETTE_RESET;
        lcd_regs[ADDR_OBP1[3:0]] = PALETTE_RESET;
    endtask

    // Advance the predicted state by one accepted request and queue the result it causes
    task automatic predict_lcd_step(input logic [1:0] cmd, input logic [15:0] addr,
                                    input logic [7:0] wdata, input logic [7:0] cyc);
        t_lcd_result res;
        bit          mapped;
        res = '0;
        mapped = (addr >= ADDR_LCDC) && (addr <= ADDR_WX) && (addr != ADDR_DMA);
        case (cmd)
            CMD_READ: begin
                if (mapped)
                    res.rdata = (addr == ADDR_LY) ? lcd_line : lcd_regs[addr[3:0]];
            end
            CMD_WRITE: begin
                if (mapped && addr != ADDR_LY)
                    lcd_regs[addr[3:0]] = wdata;
            end
            CMD_TICK: begin
                // Accumulate with saturation, then make at most one mode step
                lcd_dots = lcd_dots + cyc;
                if (lcd_dots > DOT_MAX)
                    lcd_dots = DOT_MAX;
                case (lcd_mode)
                    MODE_HBLANK: begin
                        if (lcd_dots >= HBLANK_DOTS) begin
                            lcd_dots = lcd_dots - HBLANK_DOTS;
                            lcd_line = lcd_line + 8'd1;
                            if (lcd_line >= VISIBLE_LINES) begin
                                lcd_mode = MODE_VBLANK;
                                res.pulses.vblank_irq  = 1'b1;
                                res.pulses.frame_ready = 1'b1;
                                res.pulses.stat_irq = lcd_regs[ADDR_STAT[3:0]][STAT_VBLANK_BIT];
                            end else begin
                                lcd_mode = MODE_OAM;
                            end
                        end
                    end
                    MODE_VBLANK: begin
                        if (lcd_dots >= LINE_DOTS) begin
                            lcd_dots = lcd_dots - LINE_DOTS;
                            lcd_line = lcd_line + 8'd1;
                            if (lcd_line > LAST_LINE) begin
                                lcd_mode = MODE_OAM;
                                lcd_line = 8'd0;
                            end
                        end
                    end
                    MODE_OAM: begin
                        if (lcd_dots >= OAM_DOTS) begin
                            lcd_dots = lcd_dots - OAM_DOTS;
                            lcd_mode = MODE_VRAM;
                        end
                    end
                    default: begin
                        if (lcd_dots >= VRAM_DOTS) begin
                            lcd_dots = lcd_dots - VRAM_DOTS;
                            lcd_mode = MODE_HBLANK;
                            res.pulses.render_line = 1'b1;
                        end
                    end
                endcase
            end
            default: ;
        endcase
        res.mode = lcd_mode;
        res.line = lcd_line;
        pending_results.push_back(res);
    endtask

    // Offer one request, hold it until the block takes it, then predict its result.
    // Idle gaps come before the request so they land on every phase of the block.
    task automatic send_request(input logic [1:0] cmd, input logic [15:0] addr,
                                input logic [7:0] wdata, input logic [7:0] cyc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_cmd    <= cmd;
        i_addr   <= addr;
        i_wdata  <= wdata;
        i_cycles <= cyc;
        do @(posedge i_clk); while (o_stall);
        predict_lcd_step(cmd, addr, wdata, cyc);
    endtask

    function automatic logic [15:0] pick_lcd_addr();
        if ($urandom_range(99) < 85)
            return ADDR_LCDC + 16'($urandom_range(11));
        return 16'($urandom());
    endfunction

    function automatic logic [7:0] pick_tick_cycles();
        int c;
        c = $urandom_range(99);
        // Mostly large ticks so that the mode sequence moves along often
        if (c < 60)
            return 8'($urandom_range(255, 80));
        if (c < 85)
            return 8'($urandom_range(255));
        return 8'($urandom_range(15));
    endfunction

    task automatic test_reset_values();
        for (int a = ADDR_LCDC; a <= ADDR_WX; a++)
            send_request(CMD_READ, 16'(a), 8'($urandom()), 8'($urandom()));
    endtask

    task automatic test_register_access();
        // Writes to the line register, the gap and far outside the window do nothing
        send_request(CMD_WRITE, ADDR_LY, 8'hFF, 8'hFF);
        send_request(CMD_WRITE, ADDR_DMA, 8'hFF, 8'hFF);
        send_request(CMD_WRITE, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(CMD_READ, ADDR_LY, 8'h00, 8'h00);
        send_request(CMD_READ, ADDR_DMA, 8'h00, 8'h00);
        send_request(CMD_READ, 16'h0000, 8'h00, 8'h00);
        send_request(CMD_WRITE, ADDR_STAT, 8'hFF, 8'h00);
        send_request(CMD_READ, ADDR_STAT, 8'h00, 8'h00);
    endtask

    task automatic test_special_cases();
        // Unused command with every field at its top value, then ticks at both extremes
        send_request(CMD_UNUSED, 16'hFFFF, 8'hFF, 8'hFF);
        send_request(CMD_TICK, 16'h0000, 8'h00, 8'h00);
        send_request(CMD_TICK, 16'h0000, 8'h00, 8'hFF);
    endtask

    // Random mix: mostly ticks to walk through whole frames, plus bus traffic and noise.
    // Unused-command items are not counted, the block ignores them.
    task automatic test_random_traffic(input int n_items);
        int sent;
        int r;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 3) begin
                // Burst of full ticks drives the largest cycle count into the dot counter
                repeat (12) send_request(CMD_TICK, 16'($urandom()), 8'($urandom()), 8'hFF);
                sent += 12;
            end else if (r < 70) begin
                send_request(CMD_TICK, 16'($urandom()), 8'($urandom()), pick_tick_cycles());
                sent++;
            end else if (r < 84) begin
                send_request(CMD_READ, pick_lcd_addr(), 8'($urandom()), 8'($urandom()));
                sent++;
            end else if (r < 97) begin
                send_request(CMD_WRITE, pick_lcd_addr(), 8'($urandom()), 8'($urandom()));
                sent++;
            end else begin
                send_request(CMD_UNUSED, 16'($urandom()), 8'($urandom()), 8'($urandom()));
            end
        end
    endtask

    // Hold off the result side for a long stretch while requests keep coming,
    // so the pipe fills and the block raises its input stall
    task automatic test_backpressure_fill();
        send_idle_pct = 0;
        hold_request  = 1'b1;
        repeat (24)
            send_request(CMD_TICK, 16'($urandom()), 8'($urandom()), pick_tick_cycles());
    endtask

    // Drive the result-side stall: either a forced long hold or random stalls
    initial begin : result_stall_gen
        int hold_left;
        hold_left = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                i_stall <= 1'b1;
                hold_left--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Compare each taken result against the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_lcd_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_results.size() == 0) begin
                $error("result with no request outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("rdata", want.rdata, o_rdata);
                check_field("mode", want.mode, o_mode);
                check_field("line", want.line, o_line);
                check_field("vblank_irq", want.pulses.vblank_irq, o_vblank_irq);
                check_field("stat_irq", want.pulses.stat_irq, o_stat_irq);
                check_field("render_line", want.pulses.render_line, o_render_line);
                check_field("frame_ready", want.pulses.frame_ready, o_frame_ready);
            end
        end
    end

    // End the run if no handshake happens on either side for too long
    initial begin : hang_watch
        int quiet;
        quiet = 0;
        while (quiet < HANG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_cmd    = CMD_TICK;
        i_addr   = 16'd0;
        i_wdata  = 8'd0;
        i_cycles = 8'd0;
        reset_lcd_state();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, no idling on either side
        test_reset_values();
        test_register_access();
        test_special_cases();

        // Sender idles a quarter of the time, receiver most of the time
        send_idle_pct = 25;
        recv_idle_pct = 72;
        test_random_traffic(540);
        test_backpressure_fill();

        // Roles swapped
        send_idle_pct = 72;
        recv_idle_pct = 25;
        test_random_traffic(540);

        // Full rate on both sides
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(540);

        // Drop valid, drain outstanding results, then watch for strays
        i_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/lcdt_pkg.sv
rtl/lcdt_regfile.sv
rtl/lcdt_mode_timer.sv
rtl/lcd_registers_and_mode_timing_unit.sv
sim/tb.sv
